[rtl/core/upq_pkg.sv]
package upq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_TOP    = 2'd2,
        CMD_CHANGE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Operation broadcast to every cell in the row
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_CHANGE = 2'd2,
        OP_SHIFT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  prio;
        logic [IDX_W-1:0]          pop_idx;
    } t_cell_ctl;

    // Running best candidate handed from cell to cell during a scan
    typedef struct packed {
        logic                      vld;
        logic                      has;
        logic signed [DATA_W-1:0]  prio;
        logic signed [DATA_W-1:0]  value;
        logic [IDX_W-1:0]          idx;
    } t_cand;

endpackage

[rtl/core/upq_cell.sv]
module upq_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [upq_pkg::IDX_W-1:0]           i_index,
    input  logic [upq_pkg::CNT_W-1:0]           i_count,
    input  upq_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [upq_pkg::DATA_W-1:0]   i_next_value,
    input  logic signed [upq_pkg::DATA_W-1:0]   i_next_prio,
    input  upq_pkg::t_cand                      i_cand,
    output logic signed [upq_pkg::DATA_W-1:0]   o_value,
    output logic signed [upq_pkg::DATA_W-1:0]   o_prio,
    output upq_pkg::t_cand                      o_cand,
    output logic                                o_match
);
    import upq_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_prio;
    logic [CNT_W-1:0]         w_pos;
    logic                     w_live;
    logic                     w_has_next;
    t_cand                    n_cand;
    t_cand                    r_cand;

    assign w_pos      = CNT_W'(i_index);
    assign w_live     = (w_pos < i_count);
    assign w_has_next = ((w_pos + CNT_W'(1)) < i_count);
    assign o_match    = w_live && (r_value == i_ctl.value);

    // Entry storage: append, rewrite priority, or close the gap after a pop
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_PUSH: begin
                if (w_pos == i_count) begin
                    r_value <= i_ctl.value;
                    r_prio  <= i_ctl.prio;
                end
            end
            OP_CHANGE: begin
                if (o_match) begin
                    r_prio <= i_ctl.prio;
                end
            end
            OP_SHIFT: begin
                if ((i_index >= i_ctl.pop_idx) && w_has_next) begin
                    r_value <= i_next_value;
                    r_prio  <= i_next_prio;
                end
            end
            default: begin
            end
        endcase
    end

    // Take over the candidate when it is still empty or on a strictly higher priority
    always_comb begin
        n_cand = i_cand;
        if (i_cand.vld && w_live && (!i_cand.has || (r_prio > i_cand.prio))) begin
            n_cand.has   = 1'b1;
            n_cand.prio  = r_prio;
            n_cand.value = r_value;
            n_cand.idx   = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.vld <= 1'b0;
        end else begin
            r_cand.vld <= n_cand.vld;
        end
        r_cand.has   <= n_cand.has;
        r_cand.prio  <= n_cand.prio;
        r_cand.value <= n_cand.value;
        r_cand.idx   <= n_cand.idx;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;
    assign o_cand  = r_cand;

endmodule

[rtl/core/unsorted_priority_queue_unit.sv]
// Push, change-priority, and pop/top on an empty queue give their result from the
// dispatch state; other pops and tops go on to the scan state and wait there while
// the candidate walks the cell row one cell per cycle, until it leaves the last cell.
// One transaction at a time; busy drops as the one-cycle result strobe rises, so a
// new command can be taken while the strobe is high. The receiver cannot stall.
// Reset (i_rst_n low, synchronous) empties the queue and clears control; entries stay.
module unsorted_priority_queue_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_cmd,
    input  logic signed [upq_pkg::DATA_W-1:0]   i_item_value,
    input  logic signed [upq_pkg::DATA_W-1:0]   i_item_priority,
    output logic                                o_valid,
    output logic signed [upq_pkg::DATA_W-1:0]   o_out_value,
    output logic [1:0]                          o_status,
    output logic [upq_pkg::CNT_W-1:0]           o_entry_count
);
    import upq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_item_value;
    logic signed [DATA_W-1:0] r_item_prio;
    logic [CNT_W-1:0]         r_count;

    t_cell_ctl                w_ctl;
    logic                     w_launch;
    t_cand                    w_cand [0:CAPACITY];
    logic signed [DATA_W-1:0] w_value [0:CAPACITY];
    logic signed [DATA_W-1:0] w_prio  [0:CAPACITY];
    logic [CAPACITY-1:0]      w_match;
    logic                     w_full;
    logic                     w_empty;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign busy    = (r_state != S_IDLE);

    // Scan entry: an empty candidate token enters the first cell
    assign w_cand[0]         = '{vld: w_launch, has: 1'b0, prio: '0, value: '0, idx: '0};
    assign w_value[CAPACITY] = '0;
    assign w_prio[CAPACITY]  = '0;

    // Row of cells: each holds one entry, compares the passing candidate against
    // its own entry and hands it on; on a pop the popped cell and those after it
    // take their neighbour's entry together.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        upq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(g)),
            .i_count      (r_count),
            .i_ctl        (w_ctl),
            .i_next_value (w_value[g+1]),
            .i_next_prio  (w_prio[g+1]),
            .i_cand       (w_cand[g]),
            .o_value      (w_value[g]),
            .o_prio       (w_prio[g]),
            .o_cand       (w_cand[g+1]),
            .o_match      (w_match[g])
        );
    end

    // Command broadcast to the row
    always_comb begin
        w_ctl.op      = OP_HOLD;
        w_ctl.value   = r_item_value;
        w_ctl.prio    = r_item_prio;
        w_ctl.pop_idx = w_cand[CAPACITY].idx;
        w_launch      = 1'b0;
        case (r_state)
            S_DISPATCH: begin
                case (r_cmd)
                    CMD_PUSH: begin
                        if (!w_full) begin
                            w_ctl.op = OP_PUSH;
                        end
                    end
                    CMD_CHANGE: begin
                        w_ctl.op = OP_CHANGE;
                    end
                    default: begin
                        // pop and top: start the scan unless the queue is empty
                        w_launch = !w_empty;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_cand[CAPACITY].vld && (r_cmd == CMD_POP)) begin
                    w_ctl.op = OP_SHIFT;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, fill count and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd        <= t_cmd'(i_cmd);
                        r_item_value <= i_item_value;
                        r_item_prio  <= i_item_priority;
                        r_state      <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    o_out_value   <= '0;
                    o_entry_count <= r_count;
                    case (r_cmd)
                        CMD_PUSH: begin
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                            if (w_full) begin
                                o_status <= ST_FULL;
                            end else begin
                                o_status      <= ST_OK;
                                r_count       <= r_count + CNT_W'(1);
                                o_entry_count <= r_count + CNT_W'(1);
                            end
                        end
                        CMD_CHANGE: begin
                            o_valid  <= 1'b1;
                            r_state  <= S_IDLE;
                            o_status <= (|w_match) ? ST_OK : ST_NOT_FOUND;
                        end
                        default: begin
                            if (w_empty) begin
                                o_valid  <= 1'b1;
                                o_status <= ST_EMPTY;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    // Hold until the candidate leaves the last cell
                    if (w_cand[CAPACITY].vld) begin
                        o_valid       <= 1'b1;
                        o_status      <= ST_OK;
                        o_out_value   <= w_cand[CAPACITY].value;
                        o_entry_count <= r_count;
                        if (r_cmd == CMD_POP) begin
                            r_count       <= r_count - CNT_W'(1);
                            o_entry_count <= r_count - CNT_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a transaction is in flight");

    a_scan_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cand[CAPACITY].vld |-> (r_state == S_SCAN))
        else $error("candidate left the row outside a scan");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_entry_count == CNT_W'(CAPACITY)))
        else $error("full reported with free entries");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
`endif

endmodule

[bench/upq_checker.sv]
module upq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          i_cmd,
    input  logic signed [upq_pkg::DATA_W-1:0]   i_item_value,
    input  logic signed [upq_pkg::DATA_W-1:0]   i_item_priority,
    input  logic                                i_res_valid,
    input  logic signed [upq_pkg::DATA_W-1:0]   i_res_value,
    input  logic [1:0]                          i_res_status,
    input  logic [upq_pkg::CNT_W-1:0]           i_res_count,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);
    import upq_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [CNT_W-1:0]         count;
    } t_queue_result;

    // Shadow copy of the queue contents, in insertion order
    logic signed [DATA_W-1:0] shadow_value [CAPACITY];
    logic signed [DATA_W-1:0] shadow_prio  [CAPACITY];
    int                       shadow_fill = 0;

    t_queue_result expected_results [$];

    function automatic t_queue_result run_queue_command(t_cmd c,
                                                        logic signed [DATA_W-1:0] v,
                                                        logic signed [DATA_W-1:0] p);
        t_queue_result r;
        int            best;
        bit            hit;
        r.value  = '0;
        r.status = ST_OK;
        hit      = 1'b0;
        case (c)
            CMD_PUSH: begin
                if (shadow_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_value[shadow_fill] = v;
                    shadow_prio[shadow_fill]  = p;
                    shadow_fill++;
                end
            end
            CMD_POP, CMD_TOP: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // strict compare keeps the earliest entry on a tie
                    best = 0;
                    for (int i = 1; i < shadow_fill; i++)
                        if (shadow_prio[i] > shadow_prio[best])
                            best = i;
                    r.value = shadow_value[best];
                    if (c == CMD_POP) begin
                        for (int i = best; i < shadow_fill - 1; i++) begin
                            shadow_value[i] = shadow_value[i + 1];
                            shadow_prio[i]  = shadow_prio[i + 1];
                        end
                        shadow_fill--;
                    end
                end
            end
            default: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_value[i] == v) begin
                        shadow_prio[i] = p;
                        hit            = 1'b1;
                    end
                end
                if (!hit)
                    r.status = ST_NOT_FOUND;
            end
        endcase
        r.count = CNT_W'(shadow_fill);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result exp_res;
        t_queue_result new_res;
        if (!i_rst_n) begin
            shadow_fill = 0;
            expected_results.delete();
        end else begin
            // retire the result first: a new command may be taken on the same edge
            if (i_res_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d count %0d",
                             $time, i_res_value, i_res_status, i_res_count);
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_res_value !== exp_res.value) begin
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, exp_res.value, i_res_value);
                        o_fail_count++;
                    end
                    if (i_res_status !== exp_res.status) begin
                        $display("%0t: status expected %s actual %0d",
                                 $time, exp_res.status.name(), i_res_status);
                        o_fail_count++;
                    end
                    if (i_res_count !== exp_res.count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, exp_res.count, i_res_count);
                        o_fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                new_res = run_queue_command(t_cmd'(i_cmd), i_item_value, i_item_priority);
                expected_results = {expected_results, new_res};
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

[bench/tb_top.sv]
module tb_top;
    import upq_pkg::*;

    localparam int NUM_RANDOM   = 500;
    localparam int DRAIN_CYCLES = CAPACITY + 4;   // beyond the longest pop/top latency

    logic                      clk   = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                cmd   = CMD_PUSH;
    logic signed [DATA_W-1:0]  item_value    = '0;
    logic signed [DATA_W-1:0]  item_priority = '0;
    logic                      res_valid;
    logic signed [DATA_W-1:0]  res_value;
    logic [1:0]                res_status;
    logic [CNT_W-1:0]          res_count;
    int                        fail_count;
    int                        outstanding;

    // Sender idling: on by default, switched off for a long quiet stretch
    bit                        allow_idle = 1'b1;

    always #5 clk = ~clk;

    unsorted_priority_queue_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (cmd),
        .i_item_value    (item_value),
        .i_item_priority (item_priority),
        .o_valid         (res_valid),
        .o_out_value     (res_value),
        .o_status        (res_status),
        .o_entry_count   (res_count)
    );

    upq_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (cmd),
        .i_item_value    (item_value),
        .i_item_priority (item_priority),
        .i_res_valid     (res_valid),
        .i_res_value     (res_value),
        .i_res_status    (res_status),
        .i_res_count     (res_count),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // Issue one command and hold it until the block takes the transaction.
    // On return we sit at the accepting edge, so the next command can be
    // driven straight away without dropping start in between.
    task automatic issue_command(t_cmd c, logic signed [DATA_W-1:0] v,
                                 logic signed [DATA_W-1:0] p);
        int gap;
        if (allow_idle && $urandom_range(0, 99) < 7) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        cmd           <= c;
        item_value    <= v;
        item_priority <= p;
        do @(posedge clk); while (busy);
    endtask

    // Values: half the time a small pool so change-priority hits, sometimes several
    // entries at once; otherwise full-range noise to toggle every bit.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] pool [8];
        pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff,
                 32'sd5, 32'sd6, 32'sd7};
        if ($urandom_range(0, 3) < 2)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Priorities: narrow range to force ties, the extremes, or anything
    function automatic logic signed [DATA_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Alternate fill and drain phases so the count sweeps from empty to full
    function automatic t_cmd pick_command(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (filling) begin
            if (roll < 60) return CMD_PUSH;
            if (roll < 75) return CMD_POP;
            if (roll < 85) return CMD_TOP;
            return CMD_CHANGE;
        end
        if (roll < 20) return CMD_PUSH;
        if (roll < 70) return CMD_POP;
        if (roll < 85) return CMD_TOP;
        return CMD_CHANGE;
    endfunction

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        // Hold reset low from the start, then release it for good
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue first
        issue_command(CMD_POP,    32'sd0, 32'sd0);
        issue_command(CMD_TOP,    32'sd0, 32'sd0);
        issue_command(CMD_CHANGE, 32'sd5, 32'sd9);

        // Fill to capacity: extreme values and priorities, a tie at the top,
        // and value 5 stored twice for a multi-entry change
        issue_command(CMD_PUSH, 32'sh8000_0000, 32'sh8000_0000);
        issue_command(CMD_PUSH, 32'sh7fff_ffff, 32'sh7fff_ffff);
        issue_command(CMD_PUSH, 32'sd5,         32'sh7fff_ffff);
        issue_command(CMD_PUSH, -32'sd1,        32'sd0);
        issue_command(CMD_PUSH, 32'sd5,         32'sd3);
        for (int i = 0; i < CAPACITY - 5; i++)
            issue_command(CMD_PUSH, 32'sd100 + i, i - 8);

        // Full queue: push refused, then top, changes and pops
        issue_command(CMD_PUSH,   32'sd42,    32'sd42);
        issue_command(CMD_TOP,    32'sd0,     32'sd0);
        issue_command(CMD_CHANGE, 32'sd5,     32'sh7fff_ffff);
        issue_command(CMD_CHANGE, 32'sd12345, 32'sd1);
        issue_command(CMD_POP,    32'sd0,     32'sd0);
        issue_command(CMD_POP,    32'sd0,     32'sd0);

        // Random traffic
        for (int n = 0; n < NUM_RANDOM; n++) begin
            // Quiet stretch: no sender idling at all
            allow_idle = !(n >= 150 && n < 300);
            // Once, drain everything before carrying on
            if (n == 250) begin
                start <= 1'b0;
                @(negedge clk);
                while (outstanding != 0) @(negedge clk);
                @(posedge clk);
            end
            issue_command(pick_command(((n / 40) % 2) == 0), pick_value(), pick_priority());
        end
        start <= 1'b0;

        // Wait for the last transaction to come back, then let the pipe settle
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
